### rtl/core/binary_mask_grow_shrink_defines.svh
// Assertion macros shared by the mask grow/shrink RTL.
// Included by the modules that check their own logic; needs nothing else.
`ifndef BINARY_MASK_GROW_SHRINK_DEFINES_SVH
`define BINARY_MASK_GROW_SHRINK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMGS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMGS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// The expression must never be true.
`define BMGS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

### rtl/core/bmgs_pkg.sv
// Shared types and constants of the mask grow/shrink block.
// Used by every module in rtl/core; depends on nothing.
package bmgs_pkg;

   localparam int COL_W      = 8;
   localparam int LINE_W     = 8;
   localparam int ADDR_W     = COL_W + LINE_W;
   localparam int MAX_WIDTH  = 1 << COL_W;
   localparam int MAX_HEIGHT = 1 << LINE_W;
   localparam int MASK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int DIM_W      = 9;
   localparam int PASS_W     = 9;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // Request codes.
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_RUN   = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // Register indexes on the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_OPERATION    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PASS_COUNT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CLEAR_BORDER = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [COL_W-1:0]  col;
      logic [LINE_W-1:0] line;
      logic              pixel_in;
   } bmgs_req_beat_type;

   typedef struct packed {
      logic              pixel_out;
      logic [PASS_W-1:0] passes_done;
   } bmgs_rsp_beat_type;

   typedef struct packed {
      logic              operation;
      logic [PASS_W-1:0] pass_count;
      logic              clear_border;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } bmgs_cfg_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_data;
   } bmgs_mem_req_type;

   typedef struct packed {
      logic              done;
      logic [PASS_W-1:0] passes;
   } bmgs_sweep_status_type;

endpackage

### rtl/core/bmgs_csr.sv
// Configuration registers of the mask grow/shrink block behind an APB-style port.
// Depends on bmgs_pkg for the register indexes and the configuration struct.
module bmgs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bmgs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bmgs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmgs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output bmgs_pkg::bmgs_cfg_type          cfg
);

   bmgs_pkg::bmgs_cfg_type             cfg_ff;
   bmgs_pkg::bmgs_cfg_type             cfg_in;
   logic [bmgs_pkg::REG_IDX_W-1:0]     reg_idx;
   logic                               wr_strobe;

   assign reg_idx    = csr_paddr[bmgs_pkg::CSR_ADDR_W-1:2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            bmgs_pkg::REG_OPERATION:    cfg_in.operation    = csr_pwdata[0];
            bmgs_pkg::REG_PASS_COUNT:   cfg_in.pass_count   = csr_pwdata[bmgs_pkg::PASS_W-1:0];
            bmgs_pkg::REG_CLEAR_BORDER: cfg_in.clear_border = csr_pwdata[0];
            bmgs_pkg::REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_pwdata[bmgs_pkg::DIM_W-1:0];
            bmgs_pkg::REG_IMAGE_HEIGHT: cfg_in.image_height = csr_pwdata[bmgs_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         bmgs_pkg::REG_OPERATION:    csr_prdata = 32'(cfg_ff.operation);
         bmgs_pkg::REG_PASS_COUNT:   csr_prdata = 32'(cfg_ff.pass_count);
         bmgs_pkg::REG_CLEAR_BORDER: csr_prdata = 32'(cfg_ff.clear_border);
         bmgs_pkg::REG_IMAGE_WIDTH:  csr_prdata = 32'(cfg_ff.image_width);
         bmgs_pkg::REG_IMAGE_HEIGHT: csr_prdata = 32'(cfg_ff.image_height);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.operation    <= 1'b0;
         cfg_ff.pass_count   <= bmgs_pkg::PASS_W'(1);
         cfg_ff.clear_border <= 1'b0;
         cfg_ff.image_width  <= bmgs_pkg::DIM_W'(bmgs_pkg::MAX_WIDTH);
         cfg_ff.image_height <= bmgs_pkg::DIM_W'(bmgs_pkg::MAX_HEIGHT);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/bmgs_sweep.sv
// Pass sequencer: streams the mask memory row by row through two line buffers
// and writes each grown or shrunk pixel back. Depends on bmgs_pkg.
`include "binary_mask_grow_shrink_defines.svh"

module bmgs_sweep (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  bmgs_pkg::bmgs_cfg_type          cfg,
   input  logic                            mask_rd_data,
   output bmgs_pkg::bmgs_mem_req_type      mem_req,
   output bmgs_pkg::bmgs_sweep_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_RUN   = 3'b010,
      S_CHECK = 3'b100
   } sweep_state_type;

   typedef struct packed {
      logic                        pix;
      logic                        shift;
      logic                        prime;
      logic [bmgs_pkg::LINE_W-1:0] row;
      logic [bmgs_pkg::COL_W-1:0]  col;
      logic                        left_ok;
      logic                        right_ok;
      logic                        up_ok;
      logic                        down_ok;
      logic                        border;
   } stage_type;

   sweep_state_type                 state_ff, state_in;
   logic [bmgs_pkg::DIM_W-1:0]      w_ff, w_in, h_ff, h_in;
   logic                            shrink_ff, shrink_in;
   logic                            border_en_ff, border_en_in;
   logic [bmgs_pkg::PASS_W-1:0]     count_ff, count_in;
   logic [bmgs_pkg::PASS_W-1:0]     iter_ff, iter_in;
   logic                            prime_ff, prime_in;
   logic [bmgs_pkg::LINE_W-1:0]     row_ff, row_in;
   logic [bmgs_pkg::DIM_W-1:0]      k_ff, k_in;
   stage_type                       s1_ff, s1_in;
   logic                            any_set_ff, any_set_in;
   logic                            any_clear_ff, any_clear_in;
   logic                            changed_ff, changed_in;
   logic                            done_ff, done_in;
   logic [bmgs_pkg::PASS_W-1:0]     passes_ff, passes_in;
   logic                            win_l_ff, win_c_ff;
   logic                            cur_rd_ff, prev_rd_ff;

   logic                            cur_buf  [0:bmgs_pkg::MAX_WIDTH-1];
   logic                            prev_buf [0:bmgs_pkg::MAX_WIDTH-1];

   logic                            issue_on;
   logic [bmgs_pkg::DIM_W-1:0]      k_m1;
   logic [bmgs_pkg::DIM_W-1:0]      row_p1;
   logic [bmgs_pkg::DIM_W-1:0]      cfg_w, cfg_h;
   logic [bmgs_pkg::PASS_W-1:0]     iter_p1;
   logic                            grow_v, shrink_v, res_v, fin_v;
   logic                            do_pix, cur_we;
   logic                            stop_early;
   logic                            wr_row_ok;

   assign issue_on = (state_ff == S_RUN);
   assign k_m1     = k_ff - bmgs_pkg::DIM_W'(1);
   assign row_p1   = {1'b0, row_ff} + bmgs_pkg::DIM_W'(1);
   assign iter_p1  = iter_ff + bmgs_pkg::PASS_W'(1);

   assign cfg_w = (cfg.image_width > bmgs_pkg::DIM_W'(bmgs_pkg::MAX_WIDTH)) ?
                  bmgs_pkg::DIM_W'(bmgs_pkg::MAX_WIDTH) : cfg.image_width;
   assign cfg_h = (cfg.image_height > bmgs_pkg::DIM_W'(bmgs_pkg::MAX_HEIGHT)) ?
                  bmgs_pkg::DIM_W'(bmgs_pkg::MAX_HEIGHT) : cfg.image_height;

   // Issue slot k reads cur[k], prev[k-1] and the pixel below column k-1; slot k
   // then computes column k-1 in the next cycle. Slot w+1 is a bubble so that the
   // next row never reads a line buffer entry in the cycle it is written.
   always_comb begin
      s1_in          = '0;
      s1_in.pix      = issue_on && (k_ff != '0) && (k_ff <= w_ff);
      s1_in.shift    = issue_on && (k_ff <= w_ff);
      s1_in.prime    = prime_ff;
      s1_in.row      = row_ff;
      s1_in.col      = k_m1[bmgs_pkg::COL_W-1:0];
      s1_in.left_ok  = (k_ff > bmgs_pkg::DIM_W'(1));
      s1_in.right_ok = (k_ff < w_ff);
      s1_in.up_ok    = !prime_ff && (row_ff != '0);
      s1_in.down_ok  = prime_ff || (row_p1 < h_ff);
      s1_in.border   = border_en_ff && (iter_ff == '0) &&
                       ((row_ff == '0) || (row_p1 == h_ff) ||
                        (k_ff == bmgs_pkg::DIM_W'(1)) || (k_ff == w_ff));
   end

   always_comb begin
      mem_req         = '0;
      mem_req.rd_en   = s1_in.pix && s1_in.down_ok;
      mem_req.rd_addr = {(prime_ff ? bmgs_pkg::LINE_W'(0) : row_p1[bmgs_pkg::LINE_W-1:0]),
                         k_m1[bmgs_pkg::COL_W-1:0]};
      mem_req.wr_en   = do_pix;
      mem_req.wr_addr = {s1_ff.row, s1_ff.col};
      mem_req.wr_data = fin_v;
   end

   // Pixel evaluation on the registered cross neighbourhood.
   always_comb begin
      grow_v = win_c_ff | (s1_ff.left_ok & win_l_ff) | (s1_ff.right_ok & cur_rd_ff) |
               (s1_ff.up_ok & prev_rd_ff) | (s1_ff.down_ok & mask_rd_data);
      shrink_v = win_c_ff & (!s1_ff.left_ok | win_l_ff) & (!s1_ff.right_ok | cur_rd_ff) &
                 (!s1_ff.up_ok | prev_rd_ff) & (!s1_ff.down_ok | mask_rd_data);
      res_v  = shrink_ff ? shrink_v : grow_v;
      fin_v  = s1_ff.border ? 1'b0 : res_v;
      do_pix = s1_ff.pix && !s1_ff.prime;
      cur_we = s1_ff.pix && s1_ff.down_ok;
   end

   assign stop_early = shrink_ff ? !any_set_ff : !any_clear_ff;
   assign wr_row_ok  = ({1'b0, s1_ff.row} < h_ff);

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      shrink_in    = shrink_ff;
      border_en_in = border_en_ff;
      count_in     = count_ff;
      iter_in      = iter_ff;
      prime_in     = prime_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      any_set_in   = any_set_ff;
      any_clear_in = any_clear_ff;
      changed_in   = changed_ff;
      done_in      = 1'b0;
      passes_in    = passes_ff;

      if (do_pix) begin
         any_set_in   = any_set_ff | res_v;
         any_clear_in = any_clear_ff | !res_v;
         changed_in   = changed_ff | (fin_v != win_c_ff);
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               w_in         = cfg_w;
               h_in         = cfg_h;
               shrink_in    = cfg.operation;
               border_en_in = cfg.operation && cfg.clear_border;
               count_in     = cfg.pass_count;
               iter_in      = '0;
               prime_in     = 1'b1;
               row_in       = '0;
               k_in         = '0;
               any_set_in   = 1'b0;
               any_clear_in = 1'b0;
               changed_in   = 1'b0;
               if (cfg.pass_count == '0) begin
                  done_in   = 1'b1;
                  passes_in = '0;
               end else if ((cfg_w == '0) || (cfg_h == '0)) begin
                  // An empty image counts one pass and stops.
                  done_in   = 1'b1;
                  passes_in = bmgs_pkg::PASS_W'(1);
               end else begin
                  state_in  = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (k_ff == w_ff + bmgs_pkg::DIM_W'(1)) begin
               k_in = '0;
               if (prime_ff) begin
                  prime_in = 1'b0;
               end else if (row_p1 == h_ff) begin
                  state_in = S_CHECK;
               end else begin
                  row_in = row_p1[bmgs_pkg::LINE_W-1:0];
               end
            end else begin
               k_in = k_ff + bmgs_pkg::DIM_W'(1);
            end
         end
         S_CHECK: begin
            if (stop_early) begin
               done_in   = 1'b1;
               passes_in = iter_p1;
               state_in  = S_IDLE;
            end else if (!changed_ff || (iter_p1 == count_ff)) begin
               // A pass that changed nothing leaves a fixed point; the run also ends after the last pass.
               done_in   = 1'b1;
               passes_in = count_ff;
               state_in  = S_IDLE;
            end else begin
               iter_in      = iter_p1;
               prime_in     = 1'b1;
               row_in       = '0;
               k_in         = '0;
               any_set_in   = 1'b0;
               any_clear_in = 1'b0;
               changed_in   = 1'b0;
               state_in     = S_RUN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         prime_ff     <= 1'b0;
         row_ff       <= '0;
         k_ff         <= '0;
         s1_ff        <= '0;
         any_set_ff   <= 1'b0;
         any_clear_ff <= 1'b0;
         changed_ff   <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         prime_ff     <= prime_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         s1_ff        <= s1_in;
         any_set_ff   <= any_set_in;
         any_clear_ff <= any_clear_in;
         changed_ff   <= changed_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      h_ff         <= h_in;
      shrink_ff    <= shrink_in;
      border_en_ff <= border_en_in;
      count_ff     <= count_in;
      passes_ff    <= passes_in;
      if (s1_ff.shift) begin
         win_l_ff <= win_c_ff;
         win_c_ff <= cur_rd_ff;
      end
   end

   // Line buffer holding the current row, refilled with the row below.
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_buf[s1_ff.col] <= mask_rd_data;
      end
      if (issue_on) begin
         cur_rd_ff <= cur_buf[k_ff[bmgs_pkg::COL_W-1:0]];
      end
   end

   // Line buffer holding the unmodified row above.
   always_ff @(posedge clock) begin
      if (do_pix) begin
         prev_buf[s1_ff.col] <= win_c_ff;
      end
      if (issue_on) begin
         prev_rd_ff <= prev_buf[k_m1[bmgs_pkg::COL_W-1:0]];
      end
   end

   assign status.done   = done_ff;
   assign status.passes = passes_ff;

   `BMGS_ASSERT_NEXT(a_start_acts, clock, reset, start && (state_ff == S_IDLE), (state_ff == S_RUN) || done_ff)
   `BMGS_ASSERT_IMP(a_write_in_image, clock, reset, mem_req.wr_en, wr_row_ok)
   `BMGS_ASSERT_NEVER(a_state_onehot, clock, reset, !$onehot(state_ff))

endmodule

### rtl/core/binary_mask_grow_shrink.sv
// A pixel write or an unknown request produces its result beat on acceptance; a pixel
// read first registers the memory output and produces its beat from the read state.
// In a run, each pass streams every row of the image once through the single read
// port of the mask memory, one pixel a cycle.
// One request is in work at a time; a finished result may wait in a skid register.
// Reset clears control and configuration; the mask memory is undefined until written.
`include "binary_mask_grow_shrink_defines.svh"

module binary_mask_grow_shrink (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bmgs_pkg::bmgs_req_beat_type     req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bmgs_pkg::bmgs_rsp_beat_type     rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bmgs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bmgs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bmgs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_READ = 3'b010,
      T_RUN  = 3'b100
   } top_state_type;

   top_state_type                    state_ff, state_in;
   logic [bmgs_pkg::PASS_W-1:0]      last_passes_ff, last_passes_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   bmgs_pkg::bmgs_rsp_beat_type      rsp_data_ff, rsp_data_in;
   logic                             skid_valid_ff, skid_valid_in;
   bmgs_pkg::bmgs_rsp_beat_type      skid_data_ff, skid_data_in;
   logic                             mask_rd_ff;

   logic                             mask_mem [0:bmgs_pkg::MASK_DEPTH-1];

   bmgs_pkg::bmgs_cfg_type           cfg;
   bmgs_pkg::bmgs_mem_req_type       sweep_mem;
   bmgs_pkg::bmgs_sweep_status_type  sweep_st;

   logic                             req_acc;
   logic                             sweep_start;
   logic                             prod;
   bmgs_pkg::bmgs_rsp_beat_type      prod_data;
   logic                             rsp_free;
   logic                             mem_rd_en, mem_wr_en, mem_wr_data;
   logic [bmgs_pkg::ADDR_W-1:0]      mem_rd_addr, mem_wr_addr;

   bmgs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bmgs_sweep u_sweep (
      .clock        (clock),
      .reset        (reset),
      .start        (sweep_start),
      .cfg          (cfg),
      .mask_rd_data (mask_rd_ff),
      .mem_req      (sweep_mem),
      .status       (sweep_st)
   );

   assign req_stall   = (state_ff != T_IDLE) || skid_valid_ff;
   assign req_acc     = req_valid && !req_stall;
   assign sweep_start = req_acc && (req_data.req_type == bmgs_pkg::REQ_RUN);

   // The sweep owns the memory ports while a run is in work.
   always_comb begin
      if (state_ff == T_RUN) begin
         mem_rd_en   = sweep_mem.rd_en;
         mem_rd_addr = sweep_mem.rd_addr;
         mem_wr_en   = sweep_mem.wr_en;
         mem_wr_addr = sweep_mem.wr_addr;
         mem_wr_data = sweep_mem.wr_data;
      end else begin
         mem_rd_en   = req_acc && (req_data.req_type == bmgs_pkg::REQ_READ);
         mem_rd_addr = {req_data.line, req_data.col};
         mem_wr_en   = req_acc && (req_data.req_type == bmgs_pkg::REQ_WRITE);
         mem_wr_addr = {req_data.line, req_data.col};
         mem_wr_data = req_data.pixel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mask_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         mask_rd_ff <= mask_mem[mem_rd_addr];
      end
   end

   always_comb begin
      state_in       = state_ff;
      last_passes_in = last_passes_ff;
      prod           = 1'b0;
      prod_data      = '0;
      prod_data.passes_done = last_passes_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_acc) begin
               if (req_data.req_type == bmgs_pkg::REQ_RUN) begin
                  state_in = T_RUN;
               end else if (req_data.req_type == bmgs_pkg::REQ_READ) begin
                  state_in = T_READ;
               end else begin
                  prod = 1'b1;
               end
            end
         end
         T_READ: begin
            prod                = 1'b1;
            prod_data.pixel_out = mask_rd_ff;
            state_in            = T_IDLE;
         end
         T_RUN: begin
            if (sweep_st.done) begin
               prod                  = 1'b1;
               prod_data.passes_done = sweep_st.passes;
               last_passes_in        = sweep_st.passes;
               state_in              = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   // Output register with one skid entry behind it.
   always_comb begin
      rsp_free      = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (prod) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = prod_data;
         end else begin
            rsp_valid_in  = 1'b0;
         end
      end else if (prod) begin
         skid_valid_in = 1'b1;
         skid_data_in  = prod_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         last_passes_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         last_passes_ff <= last_passes_in;
         rsp_valid_ff   <= rsp_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BMGS_ASSERT_NEVER(a_no_skid_overrun, clock, reset, prod && skid_valid_ff)
   `BMGS_ASSERT_IMP(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff)
   `BMGS_ASSERT_IMP(a_sweep_done_in_run, clock, reset, sweep_st.done, state_ff == T_RUN)

endmodule
